>>> sv/quote_aware_tokenizer_top_assert.svh
// assertion macros used by the tokenizer core
`ifndef QUOTE_AWARE_TOKENIZER_TOP_ASSERT_SVH
`define QUOTE_AWARE_TOKENIZER_TOP_ASSERT_SVH

// property must hold at every edge out of reset
`define QAT_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// trigger implies the consequence in the next cycle
`define QAT_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/qat_pkg.sv
// package: constants and types of the quote-aware tokenizer
package qat_pkg;

  localparam int MAX_TOKENS  = 16;
  localparam int LINE_LENGTH = 256;

  localparam logic [7:0] LAST_POS =
    (LINE_LENGTH > 256) ? 8'd255 : 8'(LINE_LENGTH - 1);
  localparam logic [4:0] MAX_TOK = 5'(MAX_TOKENS);

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_DELIMITER   = 2'd0;
  localparam logic [1:0] REG_KEEP_QUOTES = 2'd1;
  localparam logic [1:0] REG_TOKEN_LIMIT = 2'd2;

  typedef struct packed {
    logic [7:0] delimiter;
    logic       keep_quotes;
    logic [4:0] token_limit;
  } qat_cfg_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [7:0] out_pos;
    logic       token_start;
    logic [3:0] token_index;
    logic       line_done;
    logic [4:0] token_count;
    logic       overflow;
  } qat_res_t;

endpackage

>>> sv/qat_in_if.sv
// input channel: one line character per word
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

>>> sv/qat_out_if.sv
// result channel: one written character per word
interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [7:0] out_pos;
  logic       token_start;
  logic [3:0] token_index;
  logic       line_done;
  logic [4:0] token_count;
  logic       overflow;

  modport source (output valid, output out_char, output out_pos, output token_start,
                  output token_index, output line_done, output token_count,
                  output overflow, input ready);
  modport sink (input valid, input out_char, input out_pos, input token_start,
                input token_index, input line_done, input token_count,
                input overflow, output ready);
endinterface

>>> sv/qat_cfg_regs.sv
// apb configuration registers of the tokenizer
module qat_cfg_regs
  import qat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output qat_cfg_t          cfg
);

  qat_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter   <= 8'd32;
      cfg_r.keep_quotes <= 1'b0;
      cfg_r.token_limit <= 5'd16;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DELIMITER:   cfg_r.delimiter   <= cfg_pwdata[7:0];
        REG_KEEP_QUOTES: cfg_r.keep_quotes <= cfg_pwdata[0];
        REG_TOKEN_LIMIT: cfg_r.token_limit <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DELIMITER:   cfg_prdata = {24'd0, cfg_r.delimiter};
      REG_KEEP_QUOTES: cfg_prdata = {31'd0, cfg_r.keep_quotes};
      REG_TOKEN_LIMIT: cfg_prdata = {27'd0, cfg_r.token_limit};
      default:         cfg_prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/qat_core.sv
// tokenizer line state and per-character result logic
module qat_core
  import qat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_in,
  input  qat_cfg_t   cfg,
  output logic       res_valid,
  output qat_res_t   res
);

`include "quote_aware_tokenizer_top_assert.svh"

  logic       in_single_r, in_double_r, in_single_prev_r, in_double_prev_r;
  logic       inside_token_r, at_line_start_r, pos_full_r;
  logic [7:0] last_written_r, write_pos_r;
  logic [4:0] tokens_seen_r;

  logic       in_single_nxt, in_double_nxt, in_single_prev_nxt, in_double_prev_nxt;
  logic       inside_token_nxt, at_line_start_nxt, pos_full_nxt;
  logic [7:0] last_written_nxt, write_pos_nxt;
  logic [4:0] tokens_seen_nxt;

  logic       is_end, is_sq, is_dq, is_delim, iq1, iq2, keep, starts, ends;
  logic [4:0] limit;
  logic [7:0] ch;

  always_comb begin
    is_end   = (char_in == CH_NUL);
    is_sq    = (char_in == CH_SQUOTE);
    is_dq    = (char_in == CH_DQUOTE);
    is_delim = (char_in == cfg.delimiter);
    limit    = (cfg.token_limit < MAX_TOK) ? cfg.token_limit : MAX_TOK;

    in_single_nxt      = in_single_r ^ (is_sq && !in_double_r);
    in_double_nxt      = in_double_r ^ (is_dq && !in_single_r);
    iq1                = in_single_nxt || in_single_prev_r;
    iq2                = in_double_nxt || in_double_prev_r;
    in_single_prev_nxt = in_single_nxt;
    in_double_prev_nxt = in_double_nxt;
    keep = cfg.keep_quotes || !((is_sq && iq1) || (is_dq && iq2));

    // token opens after line start, a delimiter or a terminator
    starts = !inside_token_r && !is_delim &&
             (at_line_start_r || last_written_r == cfg.delimiter ||
              last_written_r == CH_NUL);
    ends   = inside_token_r && !iq1 && !iq2 && is_delim &&
             !at_line_start_r && last_written_r != cfg.delimiter;
    ch     = ends ? CH_NUL : char_in;

    inside_token_nxt  = (inside_token_r || starts) && !ends;
    at_line_start_nxt = 1'b0;
    last_written_nxt  = ch;
    tokens_seen_nxt   = tokens_seen_r;

    res             = '0;
    res.out_pos     = write_pos_r;
    res.overflow    = pos_full_r;
    res.out_char    = ch;
    if (starts && tokens_seen_r < limit) begin
      res.token_start = 1'b1;
      res.token_index = tokens_seen_r[3:0];
      tokens_seen_nxt = tokens_seen_r + 5'd1;
    end
    res.token_count = tokens_seen_nxt;

    // saturating write position
    pos_full_nxt  = pos_full_r;
    write_pos_nxt = write_pos_r;
    if (!pos_full_r) begin
      if (write_pos_r >= LAST_POS) pos_full_nxt = 1'b1;
      else write_pos_nxt = write_pos_r + 8'd1;
    end

    res_valid = is_end || keep;

    if (!keep && !is_end) begin
      inside_token_nxt  = inside_token_r;
      at_line_start_nxt = at_line_start_r;
      last_written_nxt  = last_written_r;
      tokens_seen_nxt   = tokens_seen_r;
      pos_full_nxt      = pos_full_r;
      write_pos_nxt     = write_pos_r;
    end

    if (is_end) begin
      res             = '0;
      res.out_pos     = write_pos_r;
      res.overflow    = pos_full_r;
      res.line_done   = 1'b1;
      res.token_count = tokens_seen_r;
      in_single_nxt      = 1'b0;
      in_double_nxt      = 1'b0;
      in_single_prev_nxt = 1'b0;
      in_double_prev_nxt = 1'b0;
      inside_token_nxt   = 1'b0;
      at_line_start_nxt  = 1'b1;
      pos_full_nxt       = 1'b0;
      last_written_nxt   = 8'd0;
      write_pos_nxt      = 8'd0;
      tokens_seen_nxt    = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_single_r      <= 1'b0;
      in_double_r      <= 1'b0;
      in_single_prev_r <= 1'b0;
      in_double_prev_r <= 1'b0;
      inside_token_r   <= 1'b0;
      at_line_start_r  <= 1'b1;
      pos_full_r       <= 1'b0;
      last_written_r   <= 8'd0;
      write_pos_r      <= 8'd0;
      tokens_seen_r    <= 5'd0;
    end else if (fire) begin
      in_single_r      <= in_single_nxt;
      in_double_r      <= in_double_nxt;
      in_single_prev_r <= in_single_prev_nxt;
      in_double_prev_r <= in_double_prev_nxt;
      inside_token_r   <= inside_token_nxt;
      at_line_start_r  <= at_line_start_nxt;
      pos_full_r       <= pos_full_nxt;
      last_written_r   <= last_written_nxt;
      write_pos_r      <= write_pos_nxt;
      tokens_seen_r    <= tokens_seen_nxt;
    end
  end

  `QAT_ASSERT_NEXT(a_end_clears, clk, rst_n, fire && char_in == CH_NUL, write_pos_r == 8'd0 && tokens_seen_r == 5'd0 && at_line_start_r && !pos_full_r)
  `QAT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, tokens_seen_r <= MAX_TOK)
  `QAT_ASSERT_ALWAYS(a_full_at_last, clk, rst_n, !pos_full_r || write_pos_r == LAST_POS)
  `QAT_ASSERT_ALWAYS(a_quotes_excl, clk, rst_n, !(in_single_r && in_double_r))

endmodule

>>> sv/quote_aware_tokenizer_top.sv
// a character accepted into the input stage register passes on to the result register, which drives the result word
// throughput: one character per cycle while the result channel does not hold the result register
// dropped quote characters give no result word
// reset (synchronous, active low) clears the line state and the channel valid flags
// and sets delimiter 32, keep_quotes 0, token_limit 16
module quote_aware_tokenizer_top
  import qat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  qat_in_if.sink            in_ch,
  qat_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  qat_cfg_t   cfg;
  qat_res_t   res, out_r;
  logic       res_valid;
  logic       s1_valid_r, out_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_adv, in_fire;

  qat_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qat_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .char_in   (s1_char_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // input stage moves on once the result register is free or being drained
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_ch.char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_r.out_char;
  assign out_ch.out_pos     = out_r.out_pos;
  assign out_ch.token_start = out_r.token_start;
  assign out_ch.token_index = out_r.token_index;
  assign out_ch.line_done   = out_r.line_done;
  assign out_ch.token_count = out_r.token_count;
  assign out_ch.overflow    = out_r.overflow;

endmodule

>>> sim/tb_quote_aware_tokenizer_top.sv
// testbench of the quote-aware tokenizer: random lines against a cycle-free predictor
module tb_quote_aware_tokenizer_top
  import qat_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // leading separator, quoted word, dropped quotes, byte extremes, mixed quotes, empty lines
  localparam logic [7:0] OPENING_LINE [22] = '{
    8'h20, 8'h61, CH_SQUOTE, 8'h62, 8'h20, 8'h63, CH_SQUOTE, 8'h20, 8'h20, 8'hFF, 8'h01,
    8'h20, CH_DQUOTE, 8'h78, CH_SQUOTE, 8'h79, CH_DQUOTE, 8'h20, CH_NUL, CH_NUL, 8'h20, CH_NUL
  };

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  qat_in_if  in_if();
  qat_out_if out_if();

  quote_aware_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // register copies
  logic [7:0] sep_char;
  logic       keep_q;
  logic [4:0] word_limit;

  // line state
  logic       sq_open, dq_open, sq_open_d, dq_open_d;
  logic       in_word, line_fresh, pos_sat;
  logic [7:0] last_char;
  logic [7:0] next_pos;
  logic [4:0] word_count;

  qat_res_t   tokenizer_writes[$];
  logic [7:0] line_chars[$];
  int         chars_queued = 0;
  int         chars_taken = 0;
  int         fail_count = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         calm_in = 0;
  int         calm_out = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 195) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic void clear_line();
    sq_open    = 1'b0;
    dq_open    = 1'b0;
    sq_open_d  = 1'b0;
    dq_open_d  = 1'b0;
    in_word    = 1'b0;
    line_fresh = 1'b1;
    pos_sat    = 1'b0;
    last_char  = CH_NUL;
    next_pos   = '0;
    word_count = '0;
  endfunction

  // saturates at the last position, flagging every write after it has been used
  function automatic logic [7:0] claim_pos(output logic ovf);
    logic [7:0] p;
    p   = next_pos;
    ovf = pos_sat;
    if (!pos_sat) begin
      if (next_pos >= LAST_POS) pos_sat = 1'b1;
      else next_pos++;
    end
    return p;
  endfunction

  function automatic void tokenize_char(logic [7:0] c);
    qat_res_t   w;
    logic       sq_span, dq_span;
    logic [4:0] cap;
    w = '0;
    if (c == CH_NUL) begin
      w.out_pos     = claim_pos(w.overflow);
      w.line_done   = 1'b1;
      w.token_count = word_count;
      tokenizer_writes.push_back(w);
      clear_line();
      return;
    end
    if (c == CH_SQUOTE && !dq_open) sq_open = !sq_open;
    if (c == CH_DQUOTE && !sq_open) dq_open = !dq_open;
    // delayed copies stretch the span so the closing quote counts as inside
    sq_span   = sq_open || sq_open_d;
    dq_span   = dq_open || dq_open_d;
    sq_open_d = sq_open;
    dq_open_d = dq_open;
    if (!keep_q && ((c == CH_SQUOTE && sq_span) || (c == CH_DQUOTE && dq_span))) return;
    w.out_char = c;
    if (!in_word && c != sep_char &&
        (line_fresh || last_char == sep_char || last_char == CH_NUL)) begin
      cap = (word_limit < MAX_TOK) ? word_limit : MAX_TOK;
      if (word_count < cap) begin
        w.token_start = 1'b1;
        w.token_index = word_count[3:0];
        word_count++;
      end
      in_word = 1'b1;
    end
    if (in_word && !sq_span && !dq_span && c == sep_char &&
        !line_fresh && last_char != sep_char) begin
      w.out_char = CH_NUL;
      in_word    = 1'b0;
    end
    w.out_pos     = claim_pos(w.overflow);
    last_char     = w.out_char;
    line_fresh    = 1'b0;
    w.token_count = word_count;
    tokenizer_writes.push_back(w);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      sep_char   = 8'd32;
      keep_q     = 1'b0;
      word_limit = 5'd16;
      clear_line();
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        tokenize_char(in_if.char_in);
        chars_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (line_chars.size() > 0) begin
        in_if.valid   <= 1'b1;
        in_if.char_in <= line_chars.pop_front();
        send_gap = pick_gap(calm_in);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor and back-pressure
  always @(posedge clk) begin
    qat_res_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tokenizer_writes.size() == 0) begin
        $error("result word with nothing predicted: char %0d pos %0d",
               out_if.out_char, out_if.out_pos);
        fail_count++;
      end else begin
        w = tokenizer_writes.pop_front();
        check_field("out_char", w.out_char, out_if.out_char);
        check_field("out_pos", w.out_pos, out_if.out_pos);
        check_field("token_start", w.token_start, out_if.token_start);
        check_field("token_index", w.token_index, out_if.token_index);
        check_field("line_done", w.line_done, out_if.line_done);
        check_field("token_count", w.token_count, out_if.token_count);
        check_field("overflow", w.overflow, out_if.overflow);
      end
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap(calm_out);
    end
  end

  function automatic void push_char(logic [7:0] c);
    line_chars.push_back(c);
    chars_queued++;
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == sep_char || c == CH_SQUOTE || c == CH_DQUOTE);
    return c;
  endfunction

  function automatic void queue_line(int n_words, bit noisy);
    int         r;
    logic [7:0] q;
    if (noisy) begin
      repeat ($urandom_range(1, 24)) begin
        r = $urandom_range(0, 19);
        push_char(r < 5 ? sep_char : r < 7 ? CH_SQUOTE : r < 9 ? CH_DQUOTE :
                  8'($urandom_range(1, 255)));
      end
    end else begin
      for (int w = 0; w < n_words; w++) begin
        if (w > 0 || $urandom_range(0, 4) == 0)
          repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 3) : 1) push_char(sep_char);
        r = $urandom_range(0, 9);
        if (r < 6) begin
          repeat ($urandom_range(1, 6)) push_char(word_char());
        end else if (r < 9) begin
          // quoted span holding separators and the other quote, sometimes left open
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          if ($urandom_range(0, 2) == 0) push_char(word_char());
          push_char(q);
          repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 9);
            push_char(r < 3 ? sep_char : r < 4 ? (q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE) :
                      word_char());
          end
          if ($urandom_range(0, 9) != 0) push_char(q);
        end else begin
          push_char(word_char());
          push_char($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
          push_char(word_char());
        end
      end
      if ($urandom_range(0, 3) == 0) push_char(sep_char);
    end
    push_char(CH_NUL);
  endfunction

  // long enough to run the write position into saturation
  function automatic void queue_long_line(int len);
    for (int i = 0; i < len; i++)
      push_char($urandom_range(0, 5) == 0 ? sep_char : word_char());
    push_char(CH_NUL);
  endfunction

  task automatic wait_idle(int settle);
    do @(posedge clk);
    while (chars_taken != chars_queued || tokenizer_writes.size() != 0);
    // dropped quotes give no word, so let any in flight drain
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_DELIMITER:   sep_char   = data[7:0];
      REG_KEEP_QUOTES: keep_q     = data[0];
      REG_TOKEN_LIMIT: word_limit = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] sep, logic keep, logic [4:0] lim);
    apb_write(REG_DELIMITER, 32'(sep));
    apb_write(REG_KEEP_QUOTES, 32'(keep));
    apb_write(REG_TOKEN_LIMIT, 32'(lim));
  endtask

  initial begin : stimulus
    int         cfg_round;
    int         round_end;
    int         r;
    logic [7:0] sep;
    logic [4:0] lim;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.char_in = '0;
    out_if.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_LINE[i]) push_char(OPENING_LINE[i]);

    cfg_round = 1;
    while (chars_queued < 1850) begin
      wait_idle(4);
      case (cfg_round)
        1: set_config(8'h20, 1'b1, 5'd16);
        2: set_config(8'h2C, 1'b0, 5'd1);
        3: set_config(8'h00, 1'b0, 5'd0);
        4: set_config(8'hFF, 1'b1, 5'd2);
        5: set_config(CH_SQUOTE, 1'b0, 5'd16);
        6: set_config(CH_DQUOTE, 1'b1, 5'd31);
        default: begin
          r   = $urandom_range(0, 3);
          sep = r == 0 ? 8'h20 : r == 1 ? 8'h2C : r == 2 ? 8'h09 : 8'($urandom_range(1, 255));
          lim = $urandom_range(0, 9) < 8 ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
          set_config(sep, 1'($urandom_range(0, 1)), lim);
        end
      endcase
      if (cfg_round == 1 || cfg_round == 4) queue_long_line(300);
      round_end = chars_queued + 130;
      while (chars_queued < round_end)
        queue_line($urandom_range(0, 5) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6),
                   $urandom_range(0, 4) == 0);
      cfg_round++;
    end

    wait_idle(10);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/qat_pkg.sv
sv/qat_in_if.sv
sv/qat_out_if.sv
sv/qat_cfg_regs.sv
sv/qat_core.sv
sv/quote_aware_tokenizer_top.sv
sim/tb_quote_aware_tokenizer_top.sv
